[rtl/core/srms_pkg.sv]
`timescale 1ns / 1ps

package srms_pkg;

  localparam int MaxRows    = 64;
  localparam int MaxCols    = 64;
  localparam int MaxEntries = 1024;
  localparam int ValueWidth = 32;

  localparam int DimW     = 7;
  localparam int RowW     = 6;
  localparam int ColW     = 6;
  localparam int CntW     = $clog2(MaxEntries + 1);
  localparam int EntAddrW = $clog2(MaxEntries);
  localparam int RsDepth  = MaxRows + 1;
  localparam int RsAddrW  = $clog2(RsDepth);
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  typedef enum logic [2:0] {
    StOk          = 3'd0,
    StOutOfRange  = 3'd1,
    StNotFound    = 3'd2,
    StNotLoaded   = 3'd3,
    StCapOverflow = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ReqLoad = 2'd0,
    ReqGet  = 2'd1,
    ReqSet  = 2'd2,
    ReqBad  = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowCount     = 2'd0,
    CfgColCount     = 2'd1,
    CfgDefaultValue = 2'd2,
    CfgUnused       = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StLdEnd = 5'b00010,
    StRdLo  = 5'b00100,
    StRdHi  = 5'b01000,
    StScan  = 5'b10000
  } state_e;

  typedef struct packed {
    logic [ColW-1:0]              col;
    logic signed [ValueWidth-1:0] value;
  } entry_t;

endpackage

[rtl/core/srms_ram.sv]
`timescale 1ns / 1ps

module srms_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sparse_row_matrix_store.sv]
`timescale 1ns / 1ps

// Compressed-row sparse matrix store, Q16.16 values. Every accepted command
// gives exactly one result word, shown for one cycle with result_valid_o; the
// receiver cannot stall it. A load element is handled straight from idle; the
// last element of the matrix also records the end of the final row, in the
// StLdEnd state. Errors found at the door (bad type, index out of range, matrix
// not loaded) are answered straight from idle. A get or set reads the row's
// start and then its end from the row-start memory (states StRdLo, StRdHi) and
// then examines one stored entry per cycle from the entry memory, at most the
// column count (64) of entries. busy is high while the state is not idle.
module sparse_row_matrix_store (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [1:0]                              req_type_i,
  input  logic [srms_pkg::RowW-1:0]               row_i,
  input  logic [srms_pkg::ColW-1:0]               col_i,
  input  logic signed [srms_pkg::ValueWidth-1:0]  value_i,
  output logic                                    result_valid_o,
  output logic [2:0]                              status_o,
  output logic signed [srms_pkg::ValueWidth-1:0]  read_value_o,
  output logic                                    load_done_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [srms_pkg::CfgIdxW-1:0]            cfg_index_i,
  input  logic [srms_pkg::CfgDataW-1:0]           cfg_data_i
);

  localparam int DimW = srms_pkg::DimW;
  localparam int CntW = srms_pkg::CntW;
  localparam int VW   = srms_pkg::ValueWidth;

  srms_pkg::state_e state_q, state_d;
  logic [DimW-1:0] row_count_q, row_count_d, col_count_q, col_count_d;
  logic signed [VW-1:0] default_value_q, default_value_d;
  logic [CntW-1:0] entry_count_q, entry_count_d;
  logic [srms_pkg::RowW-1:0] scan_row_q, scan_row_d, row_q, row_d;
  logic [srms_pkg::ColW-1:0] scan_col_q, scan_col_d, col_q, col_d;
  logic loaded_q, loaded_d;
  srms_pkg::req_e req_q, req_d;
  logic signed [VW-1:0] wval_q, wval_d;
  logic [CntW-1:0] idx_q, idx_d, hi_q, hi_d;

  logic res_valid_q, res_valid_d;
  srms_pkg::status_e res_status_q, res_status_d;
  logic signed [VW-1:0] res_value_q, res_value_d;
  logic res_done_q, res_done_d;

  // row-start memory
  logic rs_we;
  logic [srms_pkg::RsAddrW-1:0] rs_waddr, rs_raddr;
  logic [CntW-1:0] rs_wdata, rs_rdata;

  // entry memory (column and value together)
  logic ent_we;
  logic [srms_pkg::EntAddrW-1:0] ent_waddr, ent_raddr;
  srms_pkg::entry_t ent_wdata, ent_rdata;

  logic [DimW-1:0] rows_eff, cols_eff;
  logic load_first, nz, ovf, col_last, row_last, idx_range;
  logic [CntW-1:0] ec0, nxt, hi_cap;
  srms_pkg::req_e req_in;
  srms_pkg::status_e miss_status;
  logic signed [VW-1:0] miss_value;

  srms_ram #(
    .Width(CntW),
    .Depth(srms_pkg::RsDepth)
  ) u_row_start (
    .clk_i  (clk_i),
    .we_i   (rs_we),
    .waddr_i(rs_waddr),
    .wdata_i(rs_wdata),
    .raddr_i(rs_raddr),
    .rdata_o(rs_rdata)
  );

  srms_ram #(
    .Width($bits(srms_pkg::entry_t)),
    .Depth(srms_pkg::MaxEntries)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  // zero dimension counts as one, oversize as the maximum
  always_comb begin
    if (row_count_q == '0) begin
      rows_eff = DimW'(1);
    end else if (row_count_q > DimW'(srms_pkg::MaxRows)) begin
      rows_eff = DimW'(srms_pkg::MaxRows);
    end else begin
      rows_eff = row_count_q;
    end
    if (col_count_q == '0) begin
      cols_eff = DimW'(1);
    end else if (col_count_q > DimW'(srms_pkg::MaxCols)) begin
      cols_eff = DimW'(srms_pkg::MaxCols);
    end else begin
      cols_eff = col_count_q;
    end
  end

  assign req_in     = srms_pkg::req_e'(req_type_i);
  assign load_first = (scan_row_q == '0) && (scan_col_q == '0);
  assign ec0        = load_first ? '0 : entry_count_q;
  assign nz         = (value_i != '0);
  assign ovf        = nz && (ec0 >= CntW'(srms_pkg::MaxEntries));
  assign col_last   = ({1'b0, scan_col_q} + DimW'(1)) >= cols_eff;
  assign row_last   = ({1'b0, scan_row_q} + DimW'(1)) >= rows_eff;
  assign idx_range  = ({1'b0, row_i} >= rows_eff) || ({1'b0, col_i} >= cols_eff);
  assign nxt        = idx_q + CntW'(1);
  assign hi_cap     = (rs_rdata > CntW'(srms_pkg::MaxEntries)) ?
                      CntW'(srms_pkg::MaxEntries) : rs_rdata;
  assign miss_status = (req_q == srms_pkg::ReqGet) ? srms_pkg::StOk : srms_pkg::StNotFound;
  assign miss_value  = (req_q == srms_pkg::ReqGet) ? default_value_q : '0;

  always_comb begin
    state_d         = state_q;
    row_count_d     = row_count_q;
    col_count_d     = col_count_q;
    default_value_d = default_value_q;
    entry_count_d   = entry_count_q;
    scan_row_d      = scan_row_q;
    scan_col_d      = scan_col_q;
    loaded_d        = loaded_q;
    req_d           = req_q;
    row_d           = row_q;
    col_d           = col_q;
    wval_d          = wval_q;
    idx_d           = idx_q;
    hi_d            = hi_q;
    res_valid_d     = 1'b0;
    res_status_d    = srms_pkg::StOk;
    res_value_d     = '0;
    res_done_d      = 1'b0;
    rs_we           = 1'b0;
    rs_waddr        = '0;
    rs_wdata        = '0;
    rs_raddr        = '0;
    ent_we          = 1'b0;
    ent_waddr       = '0;
    ent_wdata       = '{col: col_q, value: wval_q};
    ent_raddr       = '0;

    if (cfg_valid_i) begin
      unique case (srms_pkg::cfg_idx_e'(cfg_index_i))
        srms_pkg::CfgRowCount: begin
          row_count_d = cfg_data_i[DimW-1:0];
          loaded_d    = 1'b0;
          scan_row_d  = '0;
          scan_col_d  = '0;
        end
        srms_pkg::CfgColCount: begin
          col_count_d = cfg_data_i[DimW-1:0];
          loaded_d    = 1'b0;
          scan_row_d  = '0;
          scan_col_d  = '0;
        end
        srms_pkg::CfgDefaultValue: begin
          default_value_d = signed'(cfg_data_i[VW-1:0]);
        end
        default: ;
      endcase
    end

    unique case (state_q)
      srms_pkg::StIdle: begin
        if (start) begin
          unique case (req_in)
            srms_pkg::ReqLoad: begin
              entry_count_d = ec0;
              if (load_first) begin
                loaded_d = 1'b0;
              end
              if (scan_col_q == '0) begin
                rs_we    = 1'b1;
                rs_waddr = srms_pkg::RsAddrW'(scan_row_q);
                rs_wdata = ec0;
              end
              res_valid_d = 1'b1;
              if (ovf) begin
                res_status_d = srms_pkg::StCapOverflow;
                scan_row_d   = '0;
                scan_col_d   = '0;
                loaded_d     = 1'b0;
              end else begin
                if (nz) begin
                  ent_we        = 1'b1;
                  ent_waddr     = ec0[srms_pkg::EntAddrW-1:0];
                  ent_wdata     = '{col: scan_col_q, value: value_i};
                  entry_count_d = ec0 + CntW'(1);
                end
                if (col_last) begin
                  scan_col_d = '0;
                  if (row_last) begin
                    // end of matrix: row end written next cycle with the result
                    scan_row_d  = '0;
                    loaded_d    = 1'b1;
                    res_valid_d = 1'b0;
                    state_d     = srms_pkg::StLdEnd;
                  end else begin
                    scan_row_d = scan_row_q + 1'b1;
                  end
                end else begin
                  scan_col_d = scan_col_q + 1'b1;
                end
              end
            end
            srms_pkg::ReqGet, srms_pkg::ReqSet: begin
              if (idx_range) begin
                res_valid_d  = 1'b1;
                res_status_d = srms_pkg::StOutOfRange;
              end else if (!loaded_q) begin
                res_valid_d  = 1'b1;
                res_status_d = srms_pkg::StNotLoaded;
              end else begin
                req_d    = req_in;
                row_d    = row_i;
                col_d    = col_i;
                wval_d   = value_i;
                rs_raddr = srms_pkg::RsAddrW'(row_i);
                state_d  = srms_pkg::StRdLo;
              end
            end
            default: begin
              res_valid_d  = 1'b1;
              res_status_d = srms_pkg::StOutOfRange;
            end
          endcase
        end
      end
      srms_pkg::StLdEnd: begin
        rs_we       = 1'b1;
        rs_waddr    = srms_pkg::RsAddrW'(rows_eff);
        rs_wdata    = entry_count_q;
        res_valid_d = 1'b1;
        res_done_d  = 1'b1;
        state_d     = srms_pkg::StIdle;
      end
      srms_pkg::StRdLo: begin
        idx_d    = rs_rdata;
        rs_raddr = srms_pkg::RsAddrW'(row_q) + srms_pkg::RsAddrW'(1);
        state_d  = srms_pkg::StRdHi;
      end
      srms_pkg::StRdHi: begin
        hi_d = hi_cap;
        if (idx_q < hi_cap) begin
          ent_raddr = idx_q[srms_pkg::EntAddrW-1:0];
          state_d   = srms_pkg::StScan;
        end else begin
          res_valid_d  = 1'b1;
          res_status_d = miss_status;
          res_value_d  = miss_value;
          state_d      = srms_pkg::StIdle;
        end
      end
      srms_pkg::StScan: begin
        if (ent_rdata.col == col_q) begin
          res_valid_d = 1'b1;
          if (req_q == srms_pkg::ReqGet) begin
            res_value_d = ent_rdata.value;
          end else begin
            ent_we    = 1'b1;
            ent_waddr = idx_q[srms_pkg::EntAddrW-1:0];
          end
          state_d = srms_pkg::StIdle;
        end else if (nxt < hi_q) begin
          idx_d     = nxt;
          ent_raddr = nxt[srms_pkg::EntAddrW-1:0];
        end else begin
          res_valid_d  = 1'b1;
          res_status_d = miss_status;
          res_value_d  = miss_value;
          state_d      = srms_pkg::StIdle;
        end
      end
      default: begin
        state_d = srms_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= srms_pkg::StIdle;
      row_count_q     <= DimW'(srms_pkg::MaxRows);
      col_count_q     <= DimW'(srms_pkg::MaxCols);
      default_value_q <= '0;
      entry_count_q   <= '0;
      scan_row_q      <= '0;
      scan_col_q      <= '0;
      loaded_q        <= 1'b0;
      res_valid_q     <= 1'b0;
      res_status_q    <= srms_pkg::StOk;
      res_value_q     <= '0;
      res_done_q      <= 1'b0;
    end else begin
      state_q         <= state_d;
      row_count_q     <= row_count_d;
      col_count_q     <= col_count_d;
      default_value_q <= default_value_d;
      entry_count_q   <= entry_count_d;
      scan_row_q      <= scan_row_d;
      scan_col_q      <= scan_col_d;
      loaded_q        <= loaded_d;
      res_valid_q     <= res_valid_d;
      res_status_q    <= res_status_d;
      res_value_q     <= res_value_d;
      res_done_q      <= res_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    row_q  <= row_d;
    col_q  <= col_d;
    wval_q <= wval_d;
    idx_q  <= idx_d;
    hi_q   <= hi_d;
  end

  assign busy           = (state_q != srms_pkg::StIdle);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign read_value_o   = res_value_q;
  assign load_done_o    = res_done_q;

`ifndef SYNTH
  a_scan_in_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srms_pkg::StScan) |-> (idx_q < hi_q))
    else $error("scan index beyond row segment");

  a_row_reads_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srms_pkg::StRdLo) |=> (state_q == srms_pkg::StRdHi))
    else $error("row end read did not follow row start read");

  a_done_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_done_o |-> (result_valid_o && (status_o == srms_pkg::StOk) && loaded_q))
    else $error("load completion without an ok result or loaded matrix");

  a_value_only_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (read_value_o != '0) |-> (result_valid_o && (status_o == srms_pkg::StOk)
                              && !load_done_o))
    else $error("read value outside a successful get");
`endif

endmodule
